FILE: hdl/dfa_pkg.sv
// ----------------------------------------------------------------------------
// dfa_pkg
// Shared types, constants and helpers of the ring fork arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package dfa_pkg;

   localparam int MAX_SEATS = 8;
   localparam int SEAT_W    = 3;
   localparam int CNT_W     = 4;
   localparam int IDX_W     = 3;

   localparam logic [CNT_W-1:0] SEAT_COUNT_MIN   = 4'd2;
   localparam logic [CNT_W-1:0] SEAT_COUNT_MAX   = 4'd8;
   localparam logic [CNT_W-1:0] SEAT_COUNT_RESET = 4'd8;

   localparam logic CMD_PICKUP  = 1'b0;
   localparam logic CMD_PUTDOWN = 1'b1;

   localparam logic KIND_GRANT = 1'b0;
   localparam logic KIND_WAIT  = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } dfa_state_type;

   typedef struct packed {
      logic apply;   // take the command and rewind the scan
      logic step;    // examine one queue entry
      logic flush;   // release the held result as the last one
   } dfa_cmd_type;

   typedef struct packed {
      logic in_range;
      logic scan_end;
   } dfa_status_type;

   // Right-hand resource of a seat: (seat + 1) mod count, count in 2..8.
   function automatic logic [SEAT_W-1:0] right_of(input logic [SEAT_W-1:0] s,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] v;
      v = {1'b0, s} + 4'd1;
      for (int i = 0; i < 4; i++) begin
         if (v >= n) begin
            v = v - n;
         end
      end
      return v[SEAT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (v < SEAT_COUNT_MIN) begin
         r = SEAT_COUNT_MIN;
      end else if (v > SEAT_COUNT_MAX) begin
         r = SEAT_COUNT_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/dining_fork_arbiter.sv
// ----------------------------------------------------------------------------
// dining_fork_arbiter
// Ring arbiter: seat i needs resources i and (i+1) mod seat_count.
// ----------------------------------------------------------------------------
//   channel   ports                                   transfer when
//   request   start, busy, req_command, req_seat      start & !busy
//   result    rsp_valid, rsp_out_seat, rsp_kind,      rsp_valid (one cycle)
//             rsp_last
//   csr       csr_valid, csr_ready, csr_seat_count    csr_valid & csr_ready
//
// A command is applied, then the scan reads one queue entry per cycle over
// the queue (up to 8 entries once the command is applied) and flushes the
// held result. Commands for seats at or beyond seat_count are taken and
// dropped. Results leave one per grant or waiting report, the last tagged by
// rsp_last as busy falls. Reset frees every resource, empties the queue and
// sets seat_count to 8. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module dining_fork_arbiter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_command,
   input  wire logic [dfa_pkg::SEAT_W-1:0]    req_seat,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [dfa_pkg::CNT_W-1:0]     csr_seat_count,
   output logic                               rsp_valid,
   output logic [dfa_pkg::SEAT_W-1:0]         rsp_out_seat,
   output logic                               rsp_kind,
   output logic                               rsp_last
);

   dfa_pkg::dfa_cmd_type    cmd;
   dfa_pkg::dfa_status_type status;

   assign csr_ready = 1'b1;

   dfa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   dfa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req_command),
      .req_seat       (req_seat),
      .csr_write      (csr_valid && csr_ready),
      .csr_seat_count (csr_seat_count),
      .rsp_valid      (rsp_valid),
      .rsp_out_seat   (rsp_out_seat),
      .rsp_kind       (rsp_kind),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

FILE: hdl/dfa_ctrl.sv
// ----------------------------------------------------------------------------
// dfa_ctrl
// Sequencer: takes a command, then steps the queue scan one entry a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire dfa_pkg::dfa_status_type status,
   output dfa_pkg::dfa_cmd_type        cmd
);

   dfa_pkg::dfa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfa_pkg::ST_IDLE: begin
            if (start && status.in_range) begin
               state_in = dfa_pkg::ST_SCAN;
            end
         end
         dfa_pkg::ST_SCAN: begin
            if (status.scan_end) begin
               state_in = dfa_pkg::ST_IDLE;
            end
         end
         default: state_in = dfa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b0;
      cmd.apply = 1'b0;
      cmd.step  = 1'b0;
      cmd.flush = 1'b0;
      unique case (state_ff)
         dfa_pkg::ST_IDLE: begin
            // out-of-ring seats are taken but change nothing
            cmd.apply = start && status.in_range;
         end
         dfa_pkg::ST_SCAN: begin
            busy      = 1'b1;
            cmd.step  = !status.scan_end;
            cmd.flush = status.scan_end;
         end
         default: busy = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/dfa_datapath.sv
// ----------------------------------------------------------------------------
// dfa_datapath
// Resource free bits, ordered request queue, scan pointer and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dfa_pkg::dfa_cmd_type              cmd,
   output dfa_pkg::dfa_status_type                status,
   input  wire logic                              req_command,
   input  wire logic [dfa_pkg::SEAT_W-1:0]        req_seat,
   input  wire logic                              csr_write,
   input  wire logic [dfa_pkg::CNT_W-1:0]         csr_seat_count,
   output logic                                   rsp_valid,
   output logic [dfa_pkg::SEAT_W-1:0]             rsp_out_seat,
   output logic                                   rsp_kind,
   output logic                                   rsp_last
);

   logic [dfa_pkg::MAX_SEATS-1:0] free_ff, free_in;
   logic [dfa_pkg::SEAT_W-1:0]    qseat_ff [dfa_pkg::MAX_SEATS];
   logic [dfa_pkg::SEAT_W-1:0]    qseat_in [dfa_pkg::MAX_SEATS];
   logic [dfa_pkg::MAX_SEATS-1:0] qrep_ff, qrep_in;
   logic [dfa_pkg::CNT_W-1:0]     qlen_ff, qlen_in;
   logic [dfa_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [dfa_pkg::CNT_W-1:0]     k_ff, k_in;

   logic                          pend_valid_ff, pend_valid_in;
   logic [dfa_pkg::SEAT_W-1:0]    pend_seat_ff, pend_seat_in;
   logic                          pend_kind_ff, pend_kind_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dfa_pkg::SEAT_W-1:0]    rsp_seat_ff, rsp_seat_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [dfa_pkg::IDX_W-1:0]     idx;
   logic [dfa_pkg::SEAT_W-1:0]    cur_seat;
   logic [dfa_pkg::SEAT_W-1:0]    cur_right;
   logic                          cur_grant;
   logic [dfa_pkg::SEAT_W-1:0]    req_right;
   logic                          found;
   logic                          new_res;
   logic [dfa_pkg::SEAT_W-1:0]    new_seat;
   logic                          new_kind;

   assign status.in_range = ({1'b0, req_seat} < count_ff);
   assign status.scan_end = (k_ff >= qlen_ff);

   assign idx       = k_ff[dfa_pkg::IDX_W-1:0];
   assign cur_seat  = qseat_ff[idx];
   assign cur_right = dfa_pkg::right_of(cur_seat, count_ff);
   assign cur_grant = free_ff[cur_seat] && free_ff[cur_right];
   assign req_right = dfa_pkg::right_of(req_seat, count_ff);

   always_comb begin
      free_in  = free_ff;
      qseat_in = qseat_ff;
      qrep_in  = qrep_ff;
      qlen_in  = qlen_ff;
      count_in = count_ff;
      k_in     = k_ff;
      found    = 1'b0;
      new_res  = 1'b0;
      new_seat = cur_seat;
      new_kind = dfa_pkg::KIND_WAIT;

      if (csr_write) begin
         count_in = dfa_pkg::clamp_count(csr_seat_count);
      end

      if (cmd.apply) begin
         k_in = '0;
         if (req_command == dfa_pkg::CMD_PICKUP) begin
            for (int j = 0; j < dfa_pkg::MAX_SEATS; j++) begin
               if ((j < qlen_ff) && (qseat_ff[j] == req_seat)) begin
                  qrep_in[j] = 1'b1;
                  found      = 1'b1;
               end
            end
            if (!found && (qlen_ff < dfa_pkg::SEAT_COUNT_MAX)) begin
               qseat_in[qlen_ff[dfa_pkg::IDX_W-1:0]] = req_seat;
               qrep_in[qlen_ff[dfa_pkg::IDX_W-1:0]]  = 1'b0;
               qlen_in = qlen_ff + 4'd1;
            end
         end else begin
            free_in[req_seat]  = 1'b1;
            free_in[req_right] = 1'b1;
         end
      end

      if (cmd.step) begin
         if (cur_grant) begin
            free_in[cur_seat]  = 1'b0;
            free_in[cur_right] = 1'b0;
            // close the gap; the pointer stays on the entry that moved in
            for (int j = 0; j < dfa_pkg::MAX_SEATS - 1; j++) begin
               if (j >= idx) begin
                  qseat_in[j] = qseat_ff[j+1];
                  qrep_in[j]  = qrep_ff[j+1];
               end
            end
            qlen_in  = qlen_ff - 4'd1;
            new_res  = 1'b1;
            new_kind = dfa_pkg::KIND_GRANT;
         end else begin
            if (!qrep_ff[idx]) begin
               qrep_in[idx] = 1'b1;
               new_res      = 1'b1;
               new_kind     = dfa_pkg::KIND_WAIT;
            end
            k_in = k_ff + 4'd1;
         end
      end
   end

   // Hold one result back so the final one of a command can carry last.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_seat_in  = pend_seat_ff;
      pend_kind_in  = pend_kind_ff;
      rsp_valid_in  = 1'b0;
      rsp_seat_in   = pend_seat_ff;
      rsp_kind_in   = pend_kind_ff;
      rsp_last_in   = 1'b0;
      if (cmd.apply) begin
         pend_valid_in = 1'b0;
      end
      if (new_res) begin
         rsp_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_seat_in  = new_seat;
         pend_kind_in  = new_kind;
      end
      if (cmd.flush) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff       <= '1;
         qlen_ff       <= '0;
         count_ff      <= dfa_pkg::SEAT_COUNT_RESET;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_ff       <= free_in;
         qlen_ff       <= qlen_in;
         count_ff      <= count_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qseat_ff     <= qseat_in;
      qrep_ff      <= qrep_in;
      pend_seat_ff <= pend_seat_in;
      pend_kind_ff <= pend_kind_in;
      rsp_seat_ff  <= rsp_seat_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_seat = rsp_seat_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/dfa_checker.sv
// ----------------------------------------------------------------------------
// dfa_checker
// Port-level checks of the ring fork arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_last
);

   // a new command never overlaps results of the previous one
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result shown right after a command transfer");

   // only the final result of a command may appear once the block is idle
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !busy) |-> rsp_last)
      else $error("non-final result while idle");

   // the last result is never followed at once by another
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result straight after a last result");

   // an earlier result of a command leaves the block still busy
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final result with the block idle");

endmodule

bind dining_fork_arbiter dfa_checker u_dfa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last)
);

`default_nettype wire
